FILE: rtl/rbp_pkg.sv
// ----------------------------------------------------------------------------
// rbp_pkg
// shared widths, latencies, cordic constants and register codes of the
// radar blip projector
// ----------------------------------------------------------------------------
package rbp_pkg;

   localparam int DEF_TRIG_FRAC_BITS = 15;
   localparam int DEF_ANGLE_BITS     = 16;

   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int LEN2_W  = 34;
   localparam int WIDTH_W = 10;
   localparam int HALF_W  = WIDTH_W - 1;
   localparam int RANGE_W = 16;
   localparam int BLIP_W  = 11;
   localparam int LQ_W    = 25;
   localparam int DQ_W    = 17;

   localparam int CORDIC_STEPS = 30;
   localparam int VEC_W        = 40;
   localparam int ROT_W        = 34;
   localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // stage counts of each unit
   localparam int VEC_LAT  = CORDIC_STEPS + 1;
   localparam int ROT_LAT  = CORDIC_STEPS + 2;
   localparam int SQRT_LAT = LQ_W;
   localparam int DIV_LAT  = DQ_W + 1;

   // stage index at which each value is held
   localparam int LEN_AT  = 2;
   localparam int TRIG_AT = VEC_LAT + ROT_LAT;
   localparam int DQ_AT   = LEN_AT + SQRT_LAT + DIV_LAT;
   localparam int PROD_AT = TRIG_AT + 1;

   typedef enum logic {
      CSR_SPRITE_WIDTH = 1'b0,
      CSR_RANGE_LIMIT  = 1'b1
   } csr_index_type;

endpackage

FILE: rtl/rbp_req_if.sv
// ----------------------------------------------------------------------------
// rbp_req_if
// target request channel: target and viewer position, viewer yaw
// ----------------------------------------------------------------------------
interface rbp_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [rbp_pkg::COORD_W-1:0] target_x;
   logic signed [rbp_pkg::COORD_W-1:0] target_y;
   logic signed [rbp_pkg::COORD_W-1:0] target_z;
   logic signed [rbp_pkg::COORD_W-1:0] viewer_x;
   logic signed [rbp_pkg::COORD_W-1:0] viewer_y;
   logic signed [rbp_pkg::COORD_W-1:0] viewer_z;
   logic        [15:0]                 view_yaw;

   modport source (output valid, target_x, target_y, target_z, viewer_x, viewer_y,
                   viewer_z, view_yaw, input ready);
   modport sink (input valid, target_x, target_y, target_z, viewer_x, viewer_y,
                 viewer_z, view_yaw, output ready);
endinterface

FILE: rtl/rbp_rsp_if.sv
// ----------------------------------------------------------------------------
// rbp_rsp_if
// blip result channel
// ----------------------------------------------------------------------------
interface rbp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              in_range;
   logic signed [rbp_pkg::BLIP_W-1:0] blip_x;
   logic signed [rbp_pkg::BLIP_W-1:0] blip_y;

   modport source (output valid, in_range, blip_x, blip_y, input ready);
   modport sink (input valid, in_range, blip_x, blip_y, output ready);
endinterface

FILE: rtl/rbp_csr_if.sv
// ----------------------------------------------------------------------------
// rbp_csr_if
// register write channel
// ----------------------------------------------------------------------------
interface rbp_csr_if;
   logic                          valid;
   logic                          ready;
   rbp_pkg::csr_index_type        index;
   logic [rbp_pkg::RANGE_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/rbp_delay.sv
// ----------------------------------------------------------------------------
// rbp_delay
// stall-aware delay line that keeps side data aligned with the datapath
// ----------------------------------------------------------------------------
module rbp_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);
   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) tap_ff[i] <= '0;
      end else if (en) begin
         tap_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign q = tap_ff[DEPTH-1];
endmodule

FILE: rtl/rbp_sqrt.sv
// ----------------------------------------------------------------------------
// rbp_sqrt
// pipelined integer square root of len2 * 2^16, one root bit per stage
// ----------------------------------------------------------------------------
module rbp_sqrt (
   input  logic                       clock,
   input  logic                       en,
   input  logic [rbp_pkg::LEN2_W-1:0] len2,
   output logic [rbp_pkg::LQ_W-1:0]   root
);
   import rbp_pkg::*;

   localparam int SQ_IN_W  = LEN2_W + 16;
   localparam int SQ_REM_W = LQ_W + 3;

   logic [SQ_IN_W-1:0]  v_ff    [SQRT_LAT];
   logic [SQ_REM_W-1:0] rem_ff  [SQRT_LAT];
   logic [LQ_W-1:0]     root_ff [SQRT_LAT];

   for (genvar k = 0; k < SQRT_LAT; k++) begin : g_step
      logic [SQ_IN_W-1:0]  v_p;
      logic [SQ_REM_W-1:0] rem_p;
      logic [LQ_W-1:0]     root_p;
      logic [SQ_REM_W-1:0] rem_sh;
      logic [SQ_REM_W-1:0] trial;

      if (k == 0) begin : g_first
         assign v_p    = {len2, 16'h0000};
         assign rem_p  = '0;
         assign root_p = '0;
      end else begin : g_next
         assign v_p    = v_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_p[SQ_REM_W-3:0], v_p[SQ_IN_W-1 -: 2]};
         trial  = SQ_REM_W'({root_p, 2'b01});
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[k] <= v_p << 2;
            if (rem_sh >= trial) begin
               rem_ff[k]  <= rem_sh - trial;
               root_ff[k] <= {root_p[LQ_W-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= rem_sh;
               root_ff[k] <= {root_p[LQ_W-2:0], 1'b0};
            end
         end
      end
   end

   assign root = root_ff[SQRT_LAT-1];
endmodule

FILE: rtl/rbp_div.sv
// ----------------------------------------------------------------------------
// rbp_div
// pixel distance: length times half width over range limit,
// one multiply stage then one quotient bit per stage
// ----------------------------------------------------------------------------
module rbp_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [rbp_pkg::LQ_W-1:0]    lq,
   input  logic [rbp_pkg::HALF_W-1:0]  half,
   input  logic [rbp_pkg::RANGE_W-1:0] range_limit,
   output logic [rbp_pkg::DQ_W-1:0]    dq
);
   import rbp_pkg::*;

   localparam int NUM_W = LQ_W - 1 + HALF_W;

   logic [NUM_W-1:0]   num_ff;
   logic [RANGE_W-1:0] rem_ff [DQ_W];
   logic [DQ_W-1:0]    low_ff [DQ_W];
   logic [DQ_W-1:0]    q_ff   [DQ_W];

   always_ff @(posedge clock) begin
      if (en) num_ff <= NUM_W'(lq[LQ_W-2:0]) * NUM_W'(half);
   end

   for (genvar j = 0; j < DQ_W; j++) begin : g_step
      logic [RANGE_W-1:0] rem_p;
      logic [DQ_W-1:0]    low_p;
      logic [DQ_W-1:0]    q_p;
      logic [RANGE_W:0]   r2;
      logic               ge;

      if (j == 0) begin : g_first
         assign rem_p = num_ff[NUM_W-1 -: RANGE_W];
         assign low_p = num_ff[DQ_W-1:0];
         assign q_p   = '0;
      end else begin : g_next
         assign rem_p = rem_ff[j-1];
         assign low_p = low_ff[j-1];
         assign q_p   = q_ff[j-1];
      end

      always_comb begin
         r2 = {rem_p, low_p[DQ_W-1]};
         ge = r2 >= {1'b0, range_limit};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= ge ? RANGE_W'(r2 - {1'b0, range_limit}) : r2[RANGE_W-1:0];
            low_ff[j] <= low_p << 1;
            q_ff[j]   <= {q_p[DQ_W-2:0], ge};
         end
      end
   end

   assign dq = q_ff[DQ_W-1];
endmodule

FILE: rtl/rbp_cordic_vec.sv
// ----------------------------------------------------------------------------
// rbp_cordic_vec
// target bearing atan2(dy, dx) as a 32-bit binary angle, one cordic
// vectoring step per stage
// ----------------------------------------------------------------------------
module rbp_cordic_vec (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [rbp_pkg::DIFF_W-1:0] dx,
   input  logic signed [rbp_pkg::DIFF_W-1:0] dy,
   output logic [31:0]                       bearing
);
   import rbp_pkg::*;

   logic signed [VEC_W-1:0] x_ff    [CORDIC_STEPS+1];
   logic signed [VEC_W-1:0] y_ff    [CORDIC_STEPS+1];
   logic [31:0]             acc_ff  [CORDIC_STEPS+1];
   logic                    zero_ff [CORDIC_STEPS+1];

   logic signed [VEC_W-1:0] x0_in;
   logic signed [VEC_W-1:0] y0_in;
   logic [31:0]             acc0_in;

   // fold the left half plane onto the right
   always_comb begin
      x0_in   = VEC_W'(dx) <<< 20;
      y0_in   = VEC_W'(dy) <<< 20;
      acc0_in = '0;
      if (x0_in[VEC_W-1]) begin
         x0_in   = -x0_in;
         y0_in   = -y0_in;
         acc0_in = 32'h8000_0000;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         acc_ff[0]  <= acc0_in;
         zero_ff[0] <= (dx == '0) && (dy == '0);
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [VEC_W-1:0] xs;
      logic signed [VEC_W-1:0] ys;
      logic                    up;

      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
         up = !y_ff[i][VEC_W-1] && (y_ff[i] != '0);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (up) begin
               x_ff[i+1]   <= x_ff[i] + ys;
               y_ff[i+1]   <= y_ff[i] - xs;
               acc_ff[i+1] <= acc_ff[i] + ATAN_TAB[i];
            end else begin
               x_ff[i+1]   <= x_ff[i] - ys;
               y_ff[i+1]   <= y_ff[i] + xs;
               acc_ff[i+1] <= acc_ff[i] - ATAN_TAB[i];
            end
         end
      end
   end

   assign bearing = zero_ff[CORDIC_STEPS] ? '0 : acc_ff[CORDIC_STEPS];
endmodule

FILE: rtl/rbp_cordic_rot.sv
// ----------------------------------------------------------------------------
// rbp_cordic_rot
// sin and cos of yaw minus bearing: angle rounding and quadrant fold,
// one cordic rotation step per stage, then rounding and saturation
// ----------------------------------------------------------------------------
module rbp_cordic_rot #(
   parameter int TRIG_FRAC_BITS = rbp_pkg::DEF_TRIG_FRAC_BITS,
   parameter int ANGLE_BITS     = rbp_pkg::DEF_ANGLE_BITS
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic [15:0]                      yaw,
   input  logic [31:0]                      bearing,
   output logic signed [TRIG_FRAC_BITS:0]   sin_q,
   output logic signed [TRIG_FRAC_BITS:0]   cos_q
);
   import rbp_pkg::*;

   localparam int          DROP    = 32 - ANGLE_BITS;
   localparam logic [31:0] ANG_RND = 32'(1) << (31 - ANGLE_BITS);
   localparam logic signed [ROT_W-1:0] HALF_PI = ROT_W'(64'sd1 <<< 30);
   localparam logic signed [ROT_W-1:0] FULL_PI = ROT_W'(64'sd1 <<< 31);
   localparam int TR_SH = 30 - TRIG_FRAC_BITS;
   localparam logic signed [ROT_W-1:0] TR_RND = ROT_W'(64'sd1 <<< (29 - TRIG_FRAC_BITS));
   localparam logic signed [ROT_W-1:0] TR_LIM = ROT_W'(64'sd1 <<< TRIG_FRAC_BITS);

   logic signed [ROT_W-1:0] x_ff   [CORDIC_STEPS+1];
   logic signed [ROT_W-1:0] y_ff   [CORDIC_STEPS+1];
   logic signed [ROT_W-1:0] z_ff   [CORDIC_STEPS+1];
   logic                    neg_ff [CORDIC_STEPS+1];
   logic signed [TRIG_FRAC_BITS:0] sin_ff;
   logic signed [TRIG_FRAC_BITS:0] cos_ff;

   logic [31:0]             rot;
   logic [31:0]             rnd_sum;
   logic [31:0]             z32;
   logic signed [ROT_W-1:0] z0_in;
   logic                    neg0_in;

   always_comb begin
      rot     = {yaw, 16'h0000} - bearing;
      rnd_sum = rot + ANG_RND;
      z32     = {rnd_sum[31:DROP], {DROP{1'b0}}};
      z0_in   = ROT_W'(signed'(z32));
      neg0_in = 1'b0;
      if (z0_in > HALF_PI) begin
         z0_in   = z0_in - FULL_PI;
         neg0_in = 1'b1;
      end else if (z0_in < -HALF_PI) begin
         z0_in   = z0_in + FULL_PI;
         neg0_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= CORDIC_GAIN;
         y_ff[0]   <= '0;
         z_ff[0]   <= z0_in;
         neg_ff[0] <= neg0_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [ROT_W-1:0] xs;
      logic signed [ROT_W-1:0] ys;
      logic signed [ROT_W-1:0] at;

      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
         at = $signed({2'b00, ATAN_TAB[i]});
      end

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[i+1] <= neg_ff[i];
            if (!z_ff[i][ROT_W-1]) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + at;
            end
         end
      end
   end

   logic signed [ROT_W-1:0] xf;
   logic signed [ROT_W-1:0] yf;
   logic signed [ROT_W-1:0] ct;
   logic signed [ROT_W-1:0] st;

   // round half up and clamp to the trig range
   always_comb begin
      xf = neg_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
      yf = neg_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
      ct = (xf + TR_RND) >>> TR_SH;
      st = (yf + TR_RND) >>> TR_SH;
      if (ct > TR_LIM - 1) ct = TR_LIM - 1;
      if (ct < -TR_LIM) ct = -TR_LIM;
      if (st > TR_LIM - 1) st = TR_LIM - 1;
      if (st < -TR_LIM) st = -TR_LIM;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= st[TRIG_FRAC_BITS:0];
         cos_ff <= ct[TRIG_FRAC_BITS:0];
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;
endmodule

FILE: rtl/radar_blip_projector_top.sv
// ----------------------------------------------------------------------------
// radar_blip_projector_top
// places one target as a blip on a round radar around the viewer
//
//   channel  dir  beat contents
//   req_ch   in   target x/y/z, viewer x/y/z, view yaw
//   rsp_ch   out  in_range, blip_x, blip_y
//   csr_ch   in   register index, write data (sprite width, range limit)
//
// one beat per cycle in and out while the pipeline is not held; the latency of a
// result is set by the two 30-stage cordic chains (bearing, then sin/cos)
// reset clears all valid bits and loads sprite width 128, range limit 16000
// the pipeline holds only when its last stage has a result and the output
// register is full and not taken; otherwise requests keep flowing
// ----------------------------------------------------------------------------
module radar_blip_projector_top #(
   parameter int TRIG_FRAC_BITS = rbp_pkg::DEF_TRIG_FRAC_BITS,
   parameter int ANGLE_BITS     = rbp_pkg::DEF_ANGLE_BITS
) (
   input logic     clock,
   input logic     reset,
   rbp_req_if.sink   req_ch,
   rbp_rsp_if.source rsp_ch,
   rbp_csr_if.sink   csr_ch
);
   import rbp_pkg::*;

   localparam int T_W = TRIG_FRAC_BITS + 1;
   localparam int P_W = T_W + DQ_W + 1;
   localparam int SH  = TRIG_FRAC_BITS + 8;

   // registers
   logic [WIDTH_W-1:0]     width_ff;
   logic [RANGE_W-1:0]     range_ff;
   logic [2*RANGE_W-1:0]   range_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_W'(128);
         range_ff <= RANGE_W'(16000);
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_SPRITE_WIDTH: width_ff <= csr_ch.data[WIDTH_W-1:0];
            CSR_RANGE_LIMIT:  range_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      range_sq_ff <= (2*RANGE_W)'(range_ff) * (2*RANGE_W)'(range_ff);
   end

   assign csr_ch.ready = 1'b1;

   logic [HALF_W-1:0] half;
   assign half = width_ff[WIDTH_W-1:1];

   // pipeline advance
   logic en;
   logic pv_last;
   logic out_valid_ff;

   assign en           = !pv_last || !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // stage 0: differences
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [15:0]              yaw_ff;
   logic                     v0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= DIFF_W'(req_ch.target_x) - DIFF_W'(req_ch.viewer_x);
         dy_ff  <= DIFF_W'(req_ch.target_y) - DIFF_W'(req_ch.viewer_y);
         dz_ff  <= DIFF_W'(req_ch.target_z) - DIFF_W'(req_ch.viewer_z);
         yaw_ff <= req_ch.view_yaw;
      end
   end

   // stage 1: squares, stage 2: squared length
   logic signed [2*DIFF_W-1:0] sqx_in, sqy_in, sqz_in;
   logic signed [2*DIFF_W-1:0] sqx_ff, sqy_ff, sqz_ff;
   logic [LEN2_W-1:0]          len2_ff;
   logic                       inr_s2;

   assign sqx_in = dx_ff * dx_ff;
   assign sqy_in = dy_ff * dy_ff;
   assign sqz_in = dz_ff * dz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         sqz_ff  <= sqz_in;
         len2_ff <= $unsigned(sqx_ff) + $unsigned(sqy_ff) + $unsigned(sqz_ff);
      end
   end

   assign inr_s2 = len2_ff < LEN2_W'(range_sq_ff);

   // length and pixel distance
   logic [LQ_W-1:0] lq;
   logic [DQ_W-1:0] dq, dq_d;

   rbp_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .len2  (len2_ff),
      .root  (lq)
   );

   rbp_div u_div (
      .clock       (clock),
      .en          (en),
      .lq          (lq),
      .half        (half),
      .range_limit (range_ff),
      .dq          (dq)
   );

   rbp_delay #(.WIDTH(DQ_W), .DEPTH(TRIG_AT - DQ_AT)) u_dq_dly (
      .clock (clock), .reset (1'b0), .en (en), .d (dq), .q (dq_d)
   );

   // bearing and rotation
   logic [31:0]             bearing;
   logic [15:0]             yaw_d;
   logic signed [T_W-1:0]   sin_q, cos_q;

   rbp_cordic_vec u_vec (
      .clock   (clock),
      .en      (en),
      .dx      (dx_ff),
      .dy      (dy_ff),
      .bearing (bearing)
   );

   rbp_delay #(.WIDTH(16), .DEPTH(VEC_LAT)) u_yaw_dly (
      .clock (clock), .reset (1'b0), .en (en), .d (yaw_ff), .q (yaw_d)
   );

   rbp_cordic_rot #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
      .ANGLE_BITS     (ANGLE_BITS)
   ) u_rot (
      .clock   (clock),
      .en      (en),
      .yaw     (yaw_d),
      .bearing (bearing),
      .sin_q   (sin_q),
      .cos_q   (cos_q)
   );

   // valid and range flag alongside
   logic inr_last;

   rbp_delay #(.WIDTH(1), .DEPTH(PROD_AT - LEN_AT)) u_inr_dly (
      .clock (clock), .reset (1'b0), .en (en), .d (inr_s2), .q (inr_last)
   );

   rbp_delay #(.WIDTH(1), .DEPTH(PROD_AT)) u_vld_dly (
      .clock (clock), .reset (reset), .en (en), .d (v0_ff), .q (pv_last)
   );

   // offset products
   logic signed [P_W-1:0] px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= P_W'(sin_q) * P_W'($signed({1'b0, dq_d}));
         py_ff <= P_W'(cos_q) * P_W'($signed({1'b0, dq_d}));
      end
   end

   // truncate toward zero and place on the sprite
   logic [P_W-1:0]          magx, magy;
   logic signed [BLIP_W:0]  offx, offy, cpix, bx, by;

   always_comb begin
      magx = px_ff[P_W-1] ? $unsigned(-px_ff) : $unsigned(px_ff);
      magy = py_ff[P_W-1] ? $unsigned(-py_ff) : $unsigned(py_ff);
      offx = $signed((BLIP_W+1)'(magx >> SH));
      offy = $signed((BLIP_W+1)'(magy >> SH));
      if (px_ff[P_W-1]) offx = -offx;
      if (py_ff[P_W-1]) offy = -offy;
      cpix = $signed({{(BLIP_W+1-HALF_W){1'b0}}, half}) - 12'sd1;
      bx   = cpix + offx - 12'sd2;
      by   = cpix - offy - 12'sd2;
   end

   // output register
   logic                     in_range_ff;
   logic signed [BLIP_W-1:0] blip_x_ff, blip_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en && pv_last) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en && pv_last) begin
         in_range_ff <= inr_last;
         blip_x_ff   <= inr_last ? bx[BLIP_W-1:0] : '0;
         blip_y_ff   <= inr_last ? by[BLIP_W-1:0] : '0;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.in_range = in_range_ff;
   assign rsp_ch.blip_x   = blip_x_ff;
   assign rsp_ch.blip_y   = blip_y_ff;

   // checks
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.in_range) |-> (rsp_ch.blip_x == '0 && rsp_ch.blip_y == '0))
      else $error("hidden blip with nonzero position");

   a_hold_on_full: assert property (@(posedge clock) disable iff (reset)
      (pv_last && out_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("pipeline advanced into a full output register");

   a_load_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(en && pv_last))
      else $error("result shown without a finished item");

endmodule

FILE: tb/rbp_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rbp_tb_if
// testbench monitor signals: busy while results are still expected
// ----------------------------------------------------------------------------
interface rbp_tb_mon_if (input logic clock);
   logic busy;
endinterface

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// random and directed regression of the radar blip projector: targets are
// sent through the request channel, an in-bench model of the distance,
// bearing and sin/cos path predicts each blip, and a scoreboard compares
// every result beat in order under several idle and stall mixes
// ----------------------------------------------------------------------------
module testbench;
   import rbp_pkg::*;

   localparam int TRIG_FB  = 15;
   localparam int ANG_B    = 16;
   localparam int DRAIN    = 200;
   localparam int WD_LIMIT = 20000;

   typedef struct packed {
      logic signed [15:0] tx, ty, tz, vx, vy, vz;
      logic [15:0]        yaw;
   } target_type;

   typedef struct packed {
      logic              in_range;
      logic signed [10:0] bx, by;
   } blip_type;

   logic clock = 0;
   logic reset = 1;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   rbp_req_if req_ch ();
   rbp_rsp_if rsp_ch ();
   rbp_csr_if csr_ch ();
   rbp_tb_mon_if i_mon (.clock(clock));

   radar_blip_projector_top i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   // ------------------------------------------------------------------ model
   longint atan_lut [30] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
   };

   class scoreboard_type;
      logic [9:0]  width_reg;
      logic [15:0] range_reg;
      blip_type    pending [$];
      int          errors;
      int          checked;
      int          hidden;

      function new();
         width_reg = 128;
         range_reg = 16000;
      endfunction

      function automatic longint floor_shift(longint v, int s);
         return v >>> s;
      endfunction

      function automatic longint root_floor(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function automatic logic [31:0] bearing(longint dx, longint dy);
         longint x, y, xs, ys;
         logic [31:0] acc;
         x = dx <<< 20;
         y = dy <<< 20;
         acc = 0;
         if (dx == 0 && dy == 0) return 0;
         if (x < 0) begin
            x = -x;
            y = -y;
            acc = 32'h80000000;
         end
         for (int i = 0; i < 30; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y > 0) begin
               x += ys; y -= xs; acc += atan_lut[i][31:0];
            end else begin
               x -= ys; y += xs; acc -= atan_lut[i][31:0];
            end
         end
         return acc;
      endfunction

      function automatic longint to_q(longint v);
         longint lim;
         lim = longint'(1) << TRIG_FB;
         v = floor_shift(v + (longint'(1) << (29 - TRIG_FB)), 30 - TRIG_FB);
         if (v > lim - 1) v = lim - 1;
         if (v < -lim) v = -lim;
         return v;
      endfunction

      function automatic void sin_cos(logic [31:0] ang, output longint s, output longint c);
         longint z, x, y, xs, ys;
         bit flip;
         z = longint'(signed'(ang));
         x = 652032874;
         y = 0;
         flip = 0;
         if (z > (longint'(1) << 30)) begin
            z -= longint'(1) << 31; flip = 1;
         end else if (z < -(longint'(1) << 30)) begin
            z += longint'(1) << 31; flip = 1;
         end
         for (int i = 0; i < 30; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0) begin
               x -= ys; y += xs; z -= atan_lut[i];
            end else begin
               x += ys; y -= xs; z += atan_lut[i];
            end
         end
         if (flip) begin
            x = -x; y = -y;
         end
         s = to_q(y);
         c = to_q(x);
      endfunction

      function automatic longint offset(longint t, longint d);
         longint p, m;
         p = t * d;
         m = (p < 0 ? -p : p) >> (TRIG_FB + 8);
         return p < 0 ? -m : m;
      endfunction

      function automatic blip_type project(target_type t);
         longint dx, dy, dz, cpix, s, c, bx, by;
         longint unsigned len2, half, lq, dq;
         logic [31:0] rot, q;
         blip_type r;
         dx = longint'(t.tx) - longint'(t.vx);
         dy = longint'(t.ty) - longint'(t.vy);
         dz = longint'(t.tz) - longint'(t.vz);
         len2 = dx * dx + dy * dy + dz * dz;
         half = width_reg >> 1;
         cpix = longint'(half) - 1;
         r = '0;
         if (len2 >= longint'(range_reg) * longint'(range_reg)) return r;
         lq = root_floor(len2 << 16);
         dq = lq * half / range_reg;
         rot = {t.yaw, 16'h0} - bearing(dx, dy);
         q = (rot + (32'd1 << (31 - ANG_B))) >> (32 - ANG_B);
         sin_cos(q << (32 - ANG_B), s, c);
         bx = cpix + offset(s, longint'(dq)) - 2;
         by = cpix - offset(c, longint'(dq)) - 2;
         r.in_range = 1;
         r.bx = bx[10:0];
         r.by = by[10:0];
         return r;
      endfunction

      function void note_target(target_type t);
         pending.push_back(project(t));
      endfunction

      function void check_blip(blip_type got);
         blip_type want;
         if (pending.size() == 0) begin
            $display("%0t unexpected blip beat: %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (!want.in_range) hidden++;
         if (got.in_range !== want.in_range)
            $display("%0t in_range mismatch: expected %0d actual %0d", $time,
                     want.in_range, got.in_range);
         if (got.bx !== want.bx)
            $display("%0t blip_x mismatch: expected %0d actual %0d", $time, want.bx, got.bx);
         if (got.by !== want.by)
            $display("%0t blip_y mismatch: expected %0d actual %0d", $time, want.by, got.by);
         if (got !== want) errors++;
      endfunction
   endclass

   scoreboard_type sb;
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_rsp;
   int quiet_cycles;
   int sent;

   initial sb = new();

   // --------------------------------------------------------------- drivers
   always @(negedge clock) begin
      rsp_ch.ready <= !reset && !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_blip('{rsp_ch.in_range, rsp_ch.blip_x, rsp_ch.blip_y});
   end

   always @(posedge clock) begin
      i_mon.busy <= (sb.pending.size() != 0);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WD_LIMIT) begin
            $display("%0t watchdog: no beat for %0d cycles", $time, WD_LIMIT);
            $display("radar_blip_projector_top regression: fail");
            $finish;
         end
      end
   end

   task automatic send_target(target_type t);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(negedge clock);
      end
      req_ch.valid <= 1;
      {req_ch.target_x, req_ch.target_y, req_ch.target_z} <= {t.tx, t.ty, t.tz};
      {req_ch.viewer_x, req_ch.viewer_y, req_ch.viewer_z} <= {t.vx, t.vy, t.vz};
      req_ch.view_yaw <= t.yaw;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_target(t);
      sent++;
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      @(negedge clock);
      csr_ch.valid <= 1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == CSR_SPRITE_WIDTH) sb.width_reg = val[9:0];
      else sb.range_reg = val;
      @(negedge clock);
      csr_ch.valid <= 0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 0;
      while (i_mon.busy || sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic target_type rand_target(int span);
      target_type t;
      logic signed [15:0] v;
      v = $urandom;
      t.vx = v;
      v = $urandom; t.vy = v;
      v = $urandom; t.vz = v;
      if ($urandom_range(3) == 0) begin
         t.tx = $urandom; t.ty = $urandom; t.tz = $urandom;
      end else begin
         t.tx = t.vx + $signed(16'($urandom_range(2 * span) - span));
         t.ty = t.vy + $signed(16'($urandom_range(2 * span) - span));
         t.tz = t.vz + $signed(16'($urandom_range(2 * span) - span));
      end
      t.yaw = $urandom;
      return t;
   endfunction

   initial begin
      target_type t;
      int span;
      req_ch.valid = 0;
      {req_ch.target_x, req_ch.target_y, req_ch.target_z} = '0;
      {req_ch.viewer_x, req_ch.viewer_y, req_ch.viewer_z} = '0;
      req_ch.view_yaw = 0;
      csr_ch.valid = 0;
      csr_ch.index = CSR_SPRITE_WIDTH;
      csr_ch.data = 0;
      hold_rsp = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, target above viewer, hidden, axis bearings
      send_target('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0});
      send_target('{16'sd0, 16'sd0, 16'sd500, 16'sd0, 16'sd0, 16'sd0, 16'd1234});
      send_target('{16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0});
      send_target('{-16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF});
      send_target('{16'sd0, 16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h4000});
      send_target('{16'sd0, -16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h8000});
      send_target('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000,
                    16'hC000});
      send_target('{-16'sh8000, 16'sh7FFF, 16'sd0, 16'sh7FFF, -16'sh8000, 16'sd0, 16'd1});
      send_target('{16'sd15999, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0});
      send_target('{16'sd16000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0});
      send_target('{16'sd3, -16'sd7, 16'sd2, 16'sd0, 16'sd0, 16'sd0, 16'h2000});
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin write_reg(CSR_SPRITE_WIDTH, 16'd1023); write_reg(CSR_RANGE_LIMIT, 16'hFFFF); end
            1: begin write_reg(CSR_SPRITE_WIDTH, 16'd8);    write_reg(CSR_RANGE_LIMIT, 16'd1);    end
            2: begin write_reg(CSR_SPRITE_WIDTH, 16'd1);    write_reg(CSR_RANGE_LIMIT, 16'd300);  end
            3: begin write_reg(CSR_SPRITE_WIDTH, 16'd0);    write_reg(CSR_RANGE_LIMIT, 16'd0);    end
            default: begin
               write_reg(CSR_SPRITE_WIDTH, 16'($urandom_range(8, 1023)));
               write_reg(CSR_RANGE_LIMIT, 16'($urandom_range(1, 65535)));
            end
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         if (ph == 4) begin
            send_idle_pct = 0;
            fork
               begin
                  hold_rsp = 1;
                  repeat (300) @(posedge clock);
                  hold_rsp = 0;
               end
            join_none
         end
         span = (sb.range_reg == 0) ? 64 : int'(sb.range_reg);
         for (int k = 0; k < 118; k++) begin
            t = rand_target(($urandom_range(3) == 0) ? 65535 : span);
            send_target(t);
         end
         drain();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (DRAIN) @(posedge clock);
      $display("sent %0d targets, checked %0d blips (%0d hidden) over 8 register settings",
               sent, sb.checked, sb.hidden);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("radar_blip_projector_top regression: pass");
      end else begin
         $display("radar_blip_projector_top regression: fail");
      end
      $finish;
   end
endmodule

FILE: sim.f
rtl/rbp_pkg.sv
rtl/rbp_req_if.sv
rtl/rbp_rsp_if.sv
rtl/rbp_csr_if.sv
rtl/rbp_delay.sv
rtl/rbp_sqrt.sv
rtl/rbp_div.sv
rtl/rbp_cordic_vec.sv
rtl/rbp_cordic_rot.sv
rtl/radar_blip_projector_top.sv
tb/rbp_tb_if.sv
tb/testbench.sv
